### rtl/core/jtsp_pkg.sv
// Package for the JPEG table segment parser: payload structs, event codes,
// parser phase codes and fixed limits. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package jtsp_pkg;

   localparam int MAX_SYMBOLS_DEFAULT = 256;
   localparam int COEFF_LAST          = 63;
   localparam int COUNT_LAST          = 16;
   localparam int LEN_OVERHEAD        = 2;
   localparam int ID_MAX              = 3;

   localparam int PHASE_W = 3;

   localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
   localparam logic [PHASE_W-1:0] PH_LEN_LO = 3'd1;
   localparam logic [PHASE_W-1:0] PH_HDR    = 3'd2;
   localparam logic [PHASE_W-1:0] PH_Q_HI   = 3'd3;
   localparam logic [PHASE_W-1:0] PH_Q_LO   = 3'd4;
   localparam logic [PHASE_W-1:0] PH_COUNTS = 3'd5;
   localparam logic [PHASE_W-1:0] PH_SYMS   = 3'd6;
   localparam logic [PHASE_W-1:0] PH_SKIP   = 3'd7;

   localparam logic [1:0] EV_COEFF = 2'd0;
   localparam logic [1:0] EV_COUNT = 2'd1;
   localparam logic [1:0] EV_SYM   = 2'd2;
   localparam logic [1:0] EV_ERROR = 2'd3;

   typedef struct packed {
      logic       mode;
      logic [7:0] data_byte;
      logic       segment_start;
   } req_type;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic        huff_class;
      logic [1:0]  dest_id;
      logic [7:0]  entry_index;
      logic [15:0] value;
      logic        last;
   } rsp_type;

endpackage
`default_nettype wire

### rtl/core/jpeg_table_segment_parser.sv
// JPEG DQT/DHT table segment parser, top level.
// Depends on jtsp_pkg, jtsp_in_reg, jtsp_parser and jtsp_out_reg.
//
// Usage:
//   req channel: one segment byte per transfer, starting with the high length
//     byte flagged by segment_start; mode selects DQT (0) or DHT (1) and is
//     sampled on each table header byte.
//   rsp channel: table writes (coefficient, cumulative count, symbol) tagged
//     with class and id, or an error; last marks the write that ends the
//     segment. Bytes that cause no write give no transfer.
//   Path: a transferred byte waits in the input register, is decoded there
//     and its write goes into the result register (rsp_valid high after that).
//   Throughput: one byte per cycle while results are accepted; the per-byte
//     decode is combinational, between the input and the result register.
//   Reset: synchronous; both registers empty and the parser idle, waiting
//     for a segment start.
//   Stall: while a result waits unaccepted, the parser holds; the next byte
//     waits in the input register and req_ready drops while it is blocked.
`timescale 1ns / 1ps
`default_nettype none
module jpeg_table_segment_parser #(
   parameter int MAX_SYMBOLS = jtsp_pkg::MAX_SYMBOLS_DEFAULT
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  wire jtsp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output jtsp_pkg::rsp_type rsp_data
);

   logic              item_valid, advance, can_take, res_valid;
   jtsp_pkg::req_type item;
   jtsp_pkg::rsp_type res;

   assign advance = item_valid && can_take;

   jtsp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .pop        (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   jtsp_parser #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   jtsp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .can_take  (can_take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

### rtl/core/jtsp_in_reg.sv
// Input register of the table segment parser: holds one accepted byte.
// Depends on jtsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module jtsp_in_reg (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_ready,
   input  wire jtsp_pkg::req_type req_data,
   input  wire              pop,
   output logic             item_valid,
   output jtsp_pkg::req_type item
);

   logic              valid_ff, valid_in;
   jtsp_pkg::req_type data_ff;

   assign req_ready  = !valid_ff || pop;
   assign item_valid = valid_ff;
   assign item       = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

endmodule
`default_nettype wire

### rtl/core/jtsp_parser.sv
// Segment parser state and per-byte decode for DQT/DHT bodies.
// Depends on jtsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module jtsp_parser #(
   parameter int MAX_SYMBOLS = jtsp_pkg::MAX_SYMBOLS_DEFAULT
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               advance,
   input  wire jtsp_pkg::req_type item,
   output logic              res_valid,
   output jtsp_pkg::rsp_type res
);

   localparam int TOTAL_W = $clog2(MAX_SYMBOLS + 1);
   localparam int SUM_W   = ((TOTAL_W > 8) ? TOTAL_W : 8) + 1;

   logic [jtsp_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [15:0]        bytes_left_ff, bytes_left_in;
   logic [7:0]         length_high_ff, length_high_in;
   logic               wide_ff, wide_in;
   logic               class_ff, class_in;
   logic [1:0]         id_ff, id_in;
   logic [7:0]         pos_ff, pos_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [7:0]         coeff_high_ff, coeff_high_in;

   logic [15:0]      len, bl_dec;
   logic [3:0]       hi, lo;
   logic [SUM_W-1:0] sum;
   logic             exhausted, fail, done, emit;
   logic [1:0]       kind;
   logic [15:0]      val;

   always_comb begin
      phase_in       = phase_ff;
      bytes_left_in  = bytes_left_ff;
      length_high_in = length_high_ff;
      wide_in        = wide_ff;
      class_in       = class_ff;
      id_in          = id_ff;
      pos_in         = pos_ff;
      total_in       = total_ff;
      coeff_high_in  = coeff_high_ff;
      len       = {length_high_ff, item.data_byte};
      bl_dec    = bytes_left_ff - 16'd1;
      exhausted = (bl_dec == 16'd0);
      hi        = item.data_byte[7:4];
      lo        = item.data_byte[3:0];
      sum       = SUM_W'(total_ff) + SUM_W'(item.data_byte);
      fail      = 1'b0;
      done      = 1'b0;
      emit      = 1'b0;
      kind      = jtsp_pkg::EV_COEFF;
      val       = 16'd0;
      if (item.segment_start) begin
         length_high_in = item.data_byte;
         phase_in       = jtsp_pkg::PH_LEN_LO;
      end else if (phase_ff == jtsp_pkg::PH_LEN_LO) begin
         bytes_left_in = (len > 16'(jtsp_pkg::LEN_OVERHEAD)) ?
                         len - 16'(jtsp_pkg::LEN_OVERHEAD) : 16'd0;
         phase_in      = (bytes_left_in != 16'd0) ? jtsp_pkg::PH_HDR : jtsp_pkg::PH_IDLE;
      end else if (phase_ff >= jtsp_pkg::PH_HDR && phase_ff <= jtsp_pkg::PH_SYMS &&
                   bytes_left_ff != 16'd0) begin
         bytes_left_in = bl_dec;
         unique case (phase_ff)
            jtsp_pkg::PH_HDR: begin
               if (lo > 4'(jtsp_pkg::ID_MAX)) begin
                  fail = 1'b1;
               end else begin
                  id_in = lo[1:0];
                  if (!item.mode) begin
                     if (hi > 4'd1) begin
                        fail = 1'b1;
                     end else begin
                        wide_in  = hi[0];
                        class_in = 1'b0;
                        pos_in   = 8'd0;
                        phase_in = hi[0] ? jtsp_pkg::PH_Q_HI : jtsp_pkg::PH_Q_LO;
                     end
                  end else begin
                     class_in = (hi != 4'd0);
                     pos_in   = 8'd1;
                     total_in = '0;
                     phase_in = jtsp_pkg::PH_COUNTS;
                  end
                  if (exhausted) begin
                     fail = 1'b1;
                  end
               end
            end
            jtsp_pkg::PH_Q_HI: begin
               coeff_high_in = item.data_byte;
               phase_in      = jtsp_pkg::PH_Q_LO;
               fail          = exhausted;
            end
            jtsp_pkg::PH_Q_LO: begin
               emit = 1'b1;
               kind = jtsp_pkg::EV_COEFF;
               val  = wide_ff ? {coeff_high_ff, item.data_byte} : {8'd0, item.data_byte};
               if (pos_ff >= 8'(jtsp_pkg::COEFF_LAST)) begin
                  done = 1'b1;
               end else begin
                  pos_in   = pos_ff + 8'd1;
                  phase_in = wide_ff ? jtsp_pkg::PH_Q_HI : jtsp_pkg::PH_Q_LO;
               end
            end
            jtsp_pkg::PH_COUNTS: begin
               if (sum > SUM_W'(MAX_SYMBOLS)) begin
                  fail = 1'b1;
               end else begin
                  emit     = 1'b1;
                  kind     = jtsp_pkg::EV_COUNT;
                  val      = 16'(sum);
                  total_in = sum[TOTAL_W-1:0];
                  if (pos_ff >= 8'(jtsp_pkg::COUNT_LAST)) begin
                     if (sum == '0) begin
                        done = 1'b1;
                     end else begin
                        pos_in   = 8'd0;
                        phase_in = jtsp_pkg::PH_SYMS;
                     end
                  end else begin
                     pos_in = pos_ff + 8'd1;
                  end
               end
            end
            jtsp_pkg::PH_SYMS: begin
               emit   = 1'b1;
               kind   = jtsp_pkg::EV_SYM;
               val    = {8'd0, item.data_byte};
               done   = (SUM_W'(pos_ff) + SUM_W'(1)) >= SUM_W'(total_ff);
               pos_in = pos_ff + 8'd1;
            end
            default: begin
               fail = 1'b0;
            end
         endcase
         if (!fail && emit && !done && exhausted) begin
            fail = 1'b1;
         end
         if (!fail && done) begin
            phase_in = exhausted ? jtsp_pkg::PH_IDLE : jtsp_pkg::PH_HDR;
         end
         if (fail) begin
            phase_in = jtsp_pkg::PH_SKIP;
         end
      end
   end

   always_comb begin
      res_valid = advance && (emit || fail);
      if (fail) begin
         res = '{event_kind: jtsp_pkg::EV_ERROR, huff_class: 1'b0, dest_id: 2'd0,
                 entry_index: 8'd0, value: {8'd0, item.data_byte}, last: 1'b0};
      end else begin
         res = '{event_kind: kind, huff_class: class_ff, dest_id: id_ff,
                 entry_index: pos_ff, value: val, last: done && exhausted};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= jtsp_pkg::PH_IDLE;
         bytes_left_ff  <= 16'd0;
         length_high_ff <= 8'd0;
         wide_ff        <= 1'b0;
         class_ff       <= 1'b0;
         id_ff          <= 2'd0;
         pos_ff         <= 8'd0;
         total_ff       <= '0;
         coeff_high_ff  <= 8'd0;
      end else if (advance) begin
         phase_ff       <= phase_in;
         bytes_left_ff  <= bytes_left_in;
         length_high_ff <= length_high_in;
         wide_ff        <= wide_in;
         class_ff       <= class_in;
         id_ff          <= id_in;
         pos_ff         <= pos_in;
         total_ff       <= total_in;
         coeff_high_ff  <= coeff_high_in;
      end
   end

`ifndef SYNTHESIS
   a_reset_idle: assert property (@(posedge clock)
      reset |=> phase_ff == jtsp_pkg::PH_IDLE)
      else $error("parser not idle after reset");
   a_start_len: assert property (@(posedge clock) disable iff (reset)
      advance && item.segment_start |=> phase_ff == jtsp_pkg::PH_LEN_LO)
      else $error("segment start did not restart the length field");
   a_error_skip: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.event_kind == jtsp_pkg::EV_ERROR |=> phase_ff == jtsp_pkg::PH_SKIP)
      else $error("error transfer without skip phase");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.last |=> phase_ff == jtsp_pkg::PH_IDLE && bytes_left_ff == 16'd0)
      else $error("last transfer left segment open");
   a_total_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == jtsp_pkg::PH_SYMS |-> total_ff != '0 && total_ff <= TOTAL_W'(MAX_SYMBOLS))
      else $error("symbol total out of range");
`endif

endmodule
`default_nettype wire

### rtl/core/jtsp_out_reg.sv
// Result register of the table segment parser: holds one table write.
// Depends on jtsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module jtsp_out_reg (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  wire jtsp_pkg::rsp_type push_data,
   output logic              can_take,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output jtsp_pkg::rsp_type rsp_data
);

   logic              valid_ff, valid_in;
   jtsp_pkg::rsp_type data_ff;

   assign can_take  = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (push) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff <= push_data;
      end
   end

endmodule
`default_nettype wire

### test/jpeg_table_segment_parser_test.sv
// Self-checking bench for jpeg_table_segment_parser: queued DQT/DHT bytes, a
// byte-level table-write predictor and a result checker, random idle on both sides.
// Depends on jtsp_pkg and the jpeg_table_segment_parser RTL.
`timescale 1ns / 1ps
module jpeg_table_segment_parser_test;

   localparam int MAX_SYM     = jtsp_pkg::MAX_SYMBOLS_DEFAULT;
   localparam int RANDOM_BYTES = 380;
   localparam int STALL_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 40;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   jtsp_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   jtsp_pkg::rsp_type rsp_data;

   jpeg_table_segment_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   jtsp_pkg::req_type pending_bytes[$];
   jtsp_pkg::req_type seg_q[$];
   jtsp_pkg::rsp_type table_writes[$];
   int      bytes_total;
   int      bytes_sent;
   int      mismatches;
   int      req_gap;
   int      rsp_wait;
   int      req_pace;
   int      rsp_pace;
   int      stall_count;

   // parser state mirror
   logic [jtsp_pkg::PHASE_W-1:0] ph_q;
   logic [15:0]        left_q;
   logic [7:0]         len_hi_q;
   logic               wide_q;
   logic               class_q;
   logic [1:0]         id_q;
   logic [7:0]         pos_q;
   int                 total_q;
   logic [7:0]         coef_hi_q;

   function automatic int draw_wait(inout int pace);
      if ($urandom_range(0, 39) == 0) pace = $urandom_range(0, 2);
      case (pace)
         0: return 0;
         1: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
         default: return $urandom_range(0, 18);
      endcase
   endfunction

   function automatic void clear_parser();
      ph_q = jtsp_pkg::PH_IDLE;
      left_q = '0;
      len_hi_q = '0;
      wide_q = 1'b0;
      class_q = 1'b0;
      id_q = '0;
      pos_q = '0;
      total_q = 0;
      coef_hi_q = '0;
   endfunction

   function automatic bit fault(input logic [7:0] b, output jtsp_pkg::rsp_type w);
      ph_q = jtsp_pkg::PH_SKIP;
      w = '{jtsp_pkg::EV_ERROR, 1'b0, 2'b00, 8'h00, {8'h00, b}, 1'b0};
      return 1'b1;
   endfunction

   function automatic bit parse_byte(input jtsp_pkg::req_type r,
                                     output jtsp_pkg::rsp_type w);
      logic [7:0]  b;
      logic [3:0]  hi;
      logic [3:0]  lo;
      logic [1:0]  kind;
      logic [7:0]  idx;
      logic [15:0] val;
      logic [15:0] seg_len;
      bit          done;
      bit          exhausted;
      b = r.data_byte;
      hi = b[7:4];
      lo = b[3:0];
      w = '0;
      kind = jtsp_pkg::EV_COEFF;
      idx = '0;
      val = '0;
      done = 1'b0;
      if (r.segment_start) begin
         len_hi_q = b;
         ph_q = jtsp_pkg::PH_LEN_LO;
         return 1'b0;
      end
      if (ph_q == jtsp_pkg::PH_LEN_LO) begin
         seg_len = {len_hi_q, b};
         left_q = (seg_len > jtsp_pkg::LEN_OVERHEAD) ?
                  seg_len - 16'(jtsp_pkg::LEN_OVERHEAD) : 16'd0;
         ph_q = (left_q != 0) ? jtsp_pkg::PH_HDR : jtsp_pkg::PH_IDLE;
         return 1'b0;
      end
      if (ph_q < jtsp_pkg::PH_HDR || ph_q > jtsp_pkg::PH_SYMS || left_q == 0) return 1'b0;
      left_q = left_q - 16'd1;
      exhausted = (left_q == 0);
      case (ph_q)
         jtsp_pkg::PH_HDR: begin
            if (lo > jtsp_pkg::ID_MAX) return fault(b, w);
            id_q = lo[1:0];
            if (!r.mode) begin
               if (hi > 1) return fault(b, w);
               wide_q = hi[0];
               class_q = 1'b0;
               pos_q = '0;
               ph_q = wide_q ? jtsp_pkg::PH_Q_HI : jtsp_pkg::PH_Q_LO;
            end else begin
               class_q = (hi != 0);
               pos_q = 8'd1;
               total_q = 0;
               ph_q = jtsp_pkg::PH_COUNTS;
            end
            if (exhausted) return fault(b, w);
            return 1'b0;
         end
         jtsp_pkg::PH_Q_HI: begin
            coef_hi_q = b;
            ph_q = jtsp_pkg::PH_Q_LO;
            if (exhausted) return fault(b, w);
            return 1'b0;
         end
         jtsp_pkg::PH_Q_LO: begin
            kind = jtsp_pkg::EV_COEFF;
            idx = pos_q;
            val = wide_q ? {coef_hi_q, b} : {8'h00, b};
            if (pos_q >= jtsp_pkg::COEFF_LAST) begin
               done = 1'b1;
            end else begin
               pos_q = pos_q + 8'd1;
               ph_q = wide_q ? jtsp_pkg::PH_Q_HI : jtsp_pkg::PH_Q_LO;
            end
         end
         jtsp_pkg::PH_COUNTS: begin
            total_q = total_q + b;
            if (total_q > MAX_SYM) return fault(b, w);
            kind = jtsp_pkg::EV_COUNT;
            idx = pos_q;
            val = total_q[15:0];
            if (pos_q >= jtsp_pkg::COUNT_LAST) begin
               if (total_q == 0) begin
                  done = 1'b1;
               end else begin
                  pos_q = '0;
                  ph_q = jtsp_pkg::PH_SYMS;
               end
            end else begin
               pos_q = pos_q + 8'd1;
            end
         end
         default: begin
            kind = jtsp_pkg::EV_SYM;
            idx = pos_q;
            val = {8'h00, b};
            if (int'(pos_q) + 1 >= total_q) done = 1'b1;
            pos_q = pos_q + 8'd1;
         end
      endcase
      if (done) begin
         ph_q = exhausted ? jtsp_pkg::PH_IDLE : jtsp_pkg::PH_HDR;
         w = '{kind, class_q, id_q, idx, val, exhausted};
         return 1'b1;
      end
      if (exhausted) return fault(b, w);
      w = '{kind, class_q, id_q, idx, val, 1'b0};
      return 1'b1;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // stimulus helpers
   task automatic put(input logic m, input logic [7:0] b, input logic ss);
      pending_bytes.push_back('{m, b, ss});
   endtask

   task automatic add_body(input logic m, input logic [7:0] b);
      seg_q.push_back('{m, b, 1'b0});
   endtask

   task automatic add_dqt_table();
      logic       prec;
      logic [1:0] id;
      prec = ($urandom_range(0, 3) == 0);
      id = 2'($urandom_range(0, 3));
      add_body(1'b0, {3'b000, prec, 2'b00, id});
      repeat (64) begin
         if (prec) add_body(1'($urandom_range(0, 1)), 8'($urandom));
         add_body(1'($urandom_range(0, 1)), 8'($urandom));
      end
   endtask

   task automatic add_dht_table();
      logic [3:0] cls;
      logic [1:0] id;
      int         n;
      int         k;
      int         counts[16];
      cls = 4'($urandom_range(0, 15));
      id = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
         0: n = 0;
         1: n = $urandom_range(0, 1) ? MAX_SYM : $urandom_range(100, MAX_SYM - 1);
         default: n = $urandom_range(1, 12);
      endcase
      foreach (counts[i]) counts[i] = 0;
      repeat (n) begin
         k = $urandom_range(0, 15);
         while (counts[k] == 255) k = (k + 1) % 16;
         counts[k]++;
      end
      add_body(1'b1, {cls, 2'b00, id});
      foreach (counts[i]) add_body(1'($urandom_range(0, 1)), 8'(counts[i]));
      repeat (n) add_body(1'($urandom_range(0, 1)), 8'($urandom));
   endtask

   task automatic send_segment(input logic [15:0] seg_len);
      put(1'($urandom_range(0, 1)), seg_len[15:8], 1'b1);
      put(1'($urandom_range(0, 1)), seg_len[7:0], 1'b0);
      foreach (seg_q[i]) pending_bytes.push_back(seg_q[i]);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = draw_wait(req_pace);
      end else if (!req_valid || req_ready) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            req_data <= pending_bytes.pop_front();
            req_valid <= 1'b1;
            req_gap = draw_wait(req_pace);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor, predictor and watchdog
   always @(posedge clock) begin
      jtsp_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait = draw_wait(rsp_pace);
         stall_count = 0;
         table_writes.delete();
         clear_parser();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (table_writes.size() == 0) begin
               $error("unexpected write transfer: kind %0d value %0h",
                      rsp_data.event_kind, rsp_data.value);
               mismatches++;
            end else begin
               want = table_writes.pop_front();
               check_field("event_kind", want.event_kind, rsp_data.event_kind);
               check_field("huff_class", want.huff_class, rsp_data.huff_class);
               check_field("dest_id", want.dest_id, rsp_data.dest_id);
               check_field("entry_index", want.entry_index, rsp_data.entry_index);
               check_field("value", want.value, rsp_data.value);
               check_field("last", want.last, rsp_data.last);
            end
         end
         if (req_valid && req_ready) begin
            bytes_sent++;
            if (parse_byte(req_data, want)) table_writes.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            rsp_wait = draw_wait(rsp_pace);
            rsp_ready <= (rsp_wait == 0);
         end else if (!rsp_ready) begin
            if (rsp_wait > 0) rsp_wait--;
            rsp_ready <= (rsp_wait == 0);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_count = 0;
         else stall_count++;
         if (stall_count >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      int          sel;
      int          base;
      int          cut;
      int          flaw;
      logic [15:0] seg_len;
      logic        m;
      req_pace = 2;
      rsp_pace = 2;
      // ignored while idle
      put(1'b1, 8'hAB, 1'b0);
      // short length
      put(1'b0, 8'h00, 1'b1);
      put(1'b1, 8'h02, 1'b0);
      // maximal length, 16-bit coefficients at both extremes, then drop the table
      put(1'b1, 8'hFF, 1'b1);
      put(1'b0, 8'hFF, 1'b0);
      put(1'b0, 8'h13, 1'b0);
      put(1'b1, 8'hFF, 1'b0);
      put(1'b0, 8'hFF, 1'b0);
      put(1'b1, 8'h00, 1'b0);
      put(1'b0, 8'h00, 1'b0);
      // bad precision, then a skipped byte
      put(1'b0, 8'h00, 1'b1);
      put(1'b0, 8'h05, 1'b0);
      put(1'b0, 8'h20, 1'b0);
      put(1'b1, 8'h11, 1'b0);
      // bad Huffman table id
      put(1'b1, 8'h00, 1'b1);
      put(1'b0, 8'h05, 1'b0);
      put(1'b1, 8'hF4, 1'b0);
      // truncated coefficient table
      put(1'b0, 8'h00, 1'b1);
      put(1'b0, 8'h04, 1'b0);
      put(1'b0, 8'h01, 1'b0);
      put(1'b1, 8'h80, 1'b0);
      // length runs out on the header
      put(1'b0, 8'h00, 1'b1);
      put(1'b0, 8'h03, 1'b0);
      put(1'b0, 8'h00, 1'b0);
      // symbol total over the limit, AC class
      put(1'b0, 8'h01, 1'b1);
      put(1'b0, 8'h00, 1'b0);
      put(1'b1, 8'hF2, 1'b0);
      put(1'b0, 8'hFF, 1'b0);
      put(1'b0, 8'h02, 1'b0);

      base = pending_bytes.size();
      while (pending_bytes.size() < base + RANDOM_BYTES) begin
         sel = $urandom_range(0, 9);
         seg_q.delete();
         if (sel <= 6) begin
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1) begin
               if ($urandom_range(0, 1)) add_dqt_table();
               else add_dht_table();
            end
            seg_len = 16'(seg_q.size() + jtsp_pkg::LEN_OVERHEAD);
            flaw = $urandom_range(0, 7);
            if (flaw == 0) begin
               seg_len = 16'($urandom_range(3, seg_q.size() + 1));
            end else if (flaw == 1) begin
               cut = $urandom_range(1, seg_q.size() - 1);
               while (seg_q.size() > cut) void'(seg_q.pop_back());
            end else if (flaw == 2) begin
               repeat ($urandom_range(2, 5))
                  add_body(1'($urandom_range(0, 1)), 8'($urandom));
            end
            send_segment(seg_len);
         end else if (sel == 7) begin
            repeat ($urandom_range(4, 12))
               put(1'($urandom_range(0, 1)), 8'($urandom), $urandom_range(0, 7) == 0);
         end else if (sel == 8) begin
            m = 1'($urandom_range(0, 1));
            if (!m && $urandom_range(0, 1))
               add_body(m, {4'($urandom_range(2, 15)), 4'($urandom_range(0, 15))});
            else
               add_body(m, {4'($urandom_range(0, m ? 15 : 1)), 4'($urandom_range(4, 15))});
            repeat ($urandom_range(0, 4)) add_body(1'($urandom_range(0, 1)), 8'($urandom));
            send_segment(16'($urandom_range(3, 40)));
         end else begin
            repeat ($urandom_range(0, 3)) add_body(1'($urandom_range(0, 1)), 8'($urandom));
            send_segment(16'($urandom_range(0, 2)));
         end
      end
      bytes_total = pending_bytes.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      do @(negedge clock);
      while (bytes_sent != bytes_total || table_writes.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && table_writes.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/jtsp_pkg.sv
rtl/core/jtsp_in_reg.sv
rtl/core/jtsp_parser.sv
rtl/core/jtsp_out_reg.sv
rtl/core/jpeg_table_segment_parser.sv
test/jpeg_table_segment_parser_test.sv
